// File: sv/ppu_pkg.sv
// Shared types, constants and a saturation helper for the particle pool.
package ppu_pkg;

	localparam int POOL_SIZE_DEF = 32;
	localparam int SLOT_W        = 6;
	localparam int GRAV_W        = 25;
	localparam int DT_W          = 21;
	localparam int GDV_W         = 31;
	localparam int PRD_W         = 38;

	localparam logic signed [GRAV_W-1:0] GRAVITY_RESET = -25'sd321454;

	localparam logic [1:0] RK_SPAWN = 2'd0;
	localparam logic [1:0] RK_PART  = 2'd1;
	localparam logic [1:0] RK_EMPTY = 2'd2;

	localparam logic [15:0] ALPHA_MAX = 16'hFFFF;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [15:0]        red;
		logic [15:0]        green;
		logic [15:0]        blue;
		logic signed [31:0] life;
	} particle_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        red;
		logic [15:0]        green;
		logic [15:0]        blue;
		logic [15:0]        alpha;
	} surv_t;

	typedef struct packed {
		logic wr;
		logic keep;
	} tk_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = 40'sd2147483647;
		lo = -40'sd2147483648;
		if (v > hi) begin
			sat32 = 32'sh7FFFFFFF;
		end else if (v < lo) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

// File: sv/ppu_mem.sv
// Particle record memory: one write port, one registered read port.
module ppu_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  ppu_pkg::particle_t  wdata,
	input  logic [AW-1:0]       raddr,
	output ppu_pkg::particle_t  rdata
);
	import ppu_pkg::*;

	particle_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/ppu_tick.sv
// Three-stage tick datapath: life and gravity, velocity products, position update.
module ppu_tick #(
	parameter int AW = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        iss,
	input  logic [AW-1:0]               iss_slot,
	input  logic                        iss_live,
	input  ppu_pkg::particle_t          rd,
	input  logic [ppu_pkg::DT_W-1:0]    dt,
	input  logic signed [ppu_pkg::GDV_W-1:0] gdv,
	output ppu_pkg::tk_stat_t           stat,
	output logic [AW-1:0]               wb_slot,
	output ppu_pkg::particle_t          wb_data,
	output ppu_pkg::surv_t              surv
);
	import ppu_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic [AW-1:0]      slot_s1, slot_s2, slot_s3;
	logic               live_s1, live_s2, live_s3;
	logic               keep_s2, keep_s3;
	particle_t          p_s2, p_s3;
	logic signed [PRD_W-1:0] px_s3, py_s3, pz_s3;

	logic signed [39:0] life_d;
	logic signed [31:0] life_n;
	logic signed [31:0] vy_n;
	particle_t          p_n;
	logic signed [DT_W:0] dt_s;
	logic signed [53:0] mx, my, mz;
	logic signed [31:0] nx, ny, nz;

	assign dt_s   = $signed({1'b0, dt});
	assign life_d = 40'(rd.life) - $signed({19'd0, dt});
	assign life_n = sat32(life_d);
	assign vy_n   = sat32(40'(rd.vel_y) + 40'(gdv));

	// record with new life and gravity-adjusted vertical velocity
	always_comb begin
		p_n       = rd;
		p_n.life  = life_n;
		p_n.vel_y = vy_n;
	end

	assign mx = p_s2.vel_x * dt_s;
	assign my = p_s2.vel_y * dt_s;
	assign mz = p_s2.vel_z * dt_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= iss;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= iss_slot;
		live_s1 <= iss_live;
		slot_s2 <= slot_s1;
		live_s2 <= live_s1;
		keep_s2 <= live_s1 && (life_n > 32'sd0);
		p_s2    <= p_n;
		slot_s3 <= slot_s2;
		live_s3 <= live_s2;
		keep_s3 <= keep_s2;
		p_s3    <= p_s2;
		px_s3   <= mx[53:16];
		py_s3   <= my[53:16];
		pz_s3   <= mz[53:16];
	end

	assign nx = sat32(40'(p_s3.pos_x) + 40'(px_s3));
	assign ny = sat32(40'(p_s3.pos_y) + 40'(py_s3));
	assign nz = sat32(40'(p_s3.pos_z) + 40'(pz_s3));

	always_comb begin
		stat.wr   = v_s3 && live_s3;
		stat.keep = v_s3 && keep_s3;
		wb_slot   = slot_s3;
		wb_data       = p_s3;
		wb_data.pos_x = nx;
		wb_data.pos_y = ny;
		wb_data.pos_z = nz;
		surv.slot  = SLOT_W'(slot_s3);
		surv.pos_x = nx;
		surv.pos_y = ny;
		surv.pos_z = nz;
		surv.red   = p_s3.red;
		surv.green = p_s3.green;
		surv.blue  = p_s3.blue;
		surv.alpha = (p_s3.life > 32'sd65535) ? ALPHA_MAX : p_s3.life[15:0];
	end

endmodule

// File: sv/particle_pool_update.sv
// Top level: particle pool with spawn search and per-tick Euler update.
// Spawn: from accept to acknowledge, the free-slot search checks one slot per cycle
//   starting at the last slot used.
// Tick: one slot read per cycle, a three-stage update pipeline; each survivor is held
//   back until the next one shows, and the last one, or an empty word, is the final word.
// Results cannot be stalled; busy drops while the last word of an item is on the ports,
//   so the next word is taken at the edge that takes that last word.
// Reset: every slot dead, last used slot 0, gravity_rate back to its default.
module particle_pool_update #(
	parameter int POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic signed [31:0]                   pos_x,
	input  logic signed [31:0]                   pos_y,
	input  logic signed [31:0]                   pos_z,
	input  logic signed [31:0]                   vel_x,
	input  logic signed [31:0]                   vel_y,
	input  logic signed [31:0]                   vel_z,
	input  logic [15:0]                          red,
	input  logic [15:0]                          green,
	input  logic [15:0]                          blue,
	input  logic signed [31:0]                   life,
	input  logic [ppu_pkg::DT_W-1:0]             delta_time,
	input  logic                                 cfg_we,
	input  logic signed [ppu_pkg::GRAV_W-1:0]    cfg_data,
	output logic                                 valid,
	output logic [1:0]                           result_kind,
	output logic [ppu_pkg::SLOT_W-1:0]           slot,
	output logic                                 accepted,
	output logic signed [31:0]                   out_pos_x,
	output logic signed [31:0]                   out_pos_y,
	output logic signed [31:0]                   out_pos_z,
	output logic [15:0]                          out_red,
	output logic [15:0]                          out_green,
	output logic [15:0]                          out_blue,
	output logic [15:0]                          out_alpha,
	output logic                                 last
);
	import ppu_pkg::*;

	localparam int AW = $clog2(POOL_SIZE);
	localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_TICK, ST_DRAIN, ST_FIN} state_t;

	state_t                    state_q;
	logic signed [GRAV_W-1:0]  grav_q;
	logic [POOL_SIZE-1:0]      live_q;      // slot holds life > 0
	logic [AW-1:0]             last_used_q;
	logic [AW-1:0]             cur_q;       // scan slot or issue slot
	logic [AW-1:0]             cnt_q;       // slots checked in the spawn search
	logic [1:0]                drain_q;
	particle_t                 spawn_q;
	logic [DT_W-1:0]           dt_q;
	logic signed [GDV_W-1:0]   gdv_q;
	logic                      pend_v_q;    // survivor held back until the next one shows or the tick ends
	surv_t                     pend_q;

	logic signed [GRAV_W+DT_W:0] gprod;
	logic                      accept;
	logic                      found;
	logic                      iss;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	particle_t                 mem_wdata;
	particle_t                 mem_rdata;
	tk_stat_t                  tk_stat;
	logic [AW-1:0]             wb_slot;
	particle_t                 wb_data;
	surv_t                     surv;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign gprod  = grav_q * $signed({1'b0, delta_time});
	assign found  = (state_q == ST_SCAN) && !live_q[cur_q];
	assign iss    = (state_q == ST_TICK);

	// Spawn and tick never overlap, so one write port serves both.
	always_comb begin
		if (found) begin
			mem_we    = 1'b1;
			mem_waddr = cur_q;
			mem_wdata = spawn_q;
		end else begin
			mem_we    = tk_stat.wr;
			mem_waddr = wb_slot;
			mem_wdata = wb_data;
		end
	end

	ppu_mem #(.DEPTH(POOL_SIZE), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (cur_q),
		.rdata (mem_rdata)
	);

	ppu_tick #(.AW(AW)) u_tick (
		.clk      (clk),
		.arst_n   (arst_n),
		.iss      (iss),
		.iss_slot (cur_q),
		.iss_live (live_q[cur_q]),
		.rd       (mem_rdata),
		.dt       (dt_q),
		.gdv      (gdv_q),
		.stat     (tk_stat),
		.wb_slot  (wb_slot),
		.wb_data  (wb_data),
		.surv     (surv)
	);

	// Item and held-survivor capture; payload, no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			spawn_q.pos_x <= pos_x;
			spawn_q.pos_y <= pos_y;
			spawn_q.pos_z <= pos_z;
			spawn_q.vel_x <= vel_x;
			spawn_q.vel_y <= vel_y;
			spawn_q.vel_z <= vel_z;
			spawn_q.red   <= red;
			spawn_q.green <= green;
			spawn_q.blue  <= blue;
			spawn_q.life  <= life;
			dt_q          <= delta_time;
			gdv_q         <= gprod[GRAV_W+DT_W:16];
		end
		if (tk_stat.keep) begin
			pend_q <= surv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grav_q      <= GRAVITY_RESET;
			live_q      <= '0;
			last_used_q <= '0;
			cur_q       <= '0;
			cnt_q       <= '0;
			drain_q     <= '0;
			pend_v_q    <= 1'b0;
			valid       <= 1'b0;
			result_kind <= RK_SPAWN;
			slot        <= '0;
			accepted    <= 1'b0;
			out_pos_x   <= '0;
			out_pos_y   <= '0;
			out_pos_z   <= '0;
			out_red     <= '0;
			out_green   <= '0;
			out_blue    <= '0;
			out_alpha   <= '0;
			last        <= 1'b0;
		end else begin
			// strobe: released survivor, spawn answer, or final tick word
			valid <= (tk_stat.keep && pend_v_q) ||
				((state_q == ST_SCAN) && (found || cnt_q == LAST_SLOT)) ||
				(state_q == ST_FIN);
			if (cfg_we) begin
				grav_q <= cfg_data;
			end
			// live bits follow the writeback of the tick pipeline
			if (tk_stat.wr) begin
				live_q[wb_slot] <= tk_stat.keep;
			end
			// a new survivor releases the one held back
			if (tk_stat.keep) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					result_kind <= RK_PART;
					slot        <= pend_q.slot;
					accepted    <= 1'b0;
					out_pos_x   <= pend_q.pos_x;
					out_pos_y   <= pend_q.pos_y;
					out_pos_z   <= pend_q.pos_z;
					out_red     <= pend_q.red;
					out_green   <= pend_q.green;
					out_blue    <= pend_q.blue;
					out_alpha   <= pend_q.alpha;
					last        <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pend_v_q <= 1'b0;
						cnt_q    <= '0;
						if (kind) begin
							cur_q   <= '0;
							state_q <= ST_TICK;
						end else begin
							cur_q   <= last_used_q;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (found || cnt_q == LAST_SLOT) begin
						result_kind <= RK_SPAWN;
						slot        <= found ? SLOT_W'(cur_q) : '0;
						accepted    <= found;
						out_pos_x   <= '0;
						out_pos_y   <= '0;
						out_pos_z   <= '0;
						out_red     <= '0;
						out_green   <= '0;
						out_blue    <= '0;
						out_alpha   <= '0;
						last        <= 1'b1;
						state_q     <= ST_IDLE;
						if (found) begin
							live_q[cur_q] <= (spawn_q.life > 32'sd0);
							last_used_q   <= cur_q;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
						cur_q <= (cur_q == LAST_SLOT) ? '0 : cur_q + 1'b1;
					end
				end
				ST_TICK: begin
					if (cur_q == LAST_SLOT) begin
						drain_q <= 2'd2;
						state_q <= ST_DRAIN;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (drain_q == 2'd0) begin
						state_q <= ST_FIN;
					end else begin
						drain_q <= drain_q - 1'b1;
					end
				end
				ST_FIN: begin
					accepted    <= 1'b0;
					last        <= 1'b1;
					state_q     <= ST_IDLE;
					if (pend_v_q) begin
						result_kind <= RK_PART;
						slot        <= pend_q.slot;
						out_pos_x   <= pend_q.pos_x;
						out_pos_y   <= pend_q.pos_y;
						out_pos_z   <= pend_q.pos_z;
						out_red     <= pend_q.red;
						out_green   <= pend_q.green;
						out_blue    <= pend_q.blue;
						out_alpha   <= pend_q.alpha;
					end else begin
						result_kind <= RK_EMPTY;
						slot        <= '0;
						out_pos_x   <= '0;
						out_pos_y   <= '0;
						out_pos_z   <= '0;
						out_red     <= '0;
						out_green   <= '0;
						out_blue    <= '0;
						out_alpha   <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/ppu_chk.sv
// Port-level checker for the particle pool, bound to the top level.
module ppu_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       valid,
	input logic [1:0] result_kind,
	input logic       accepted,
	input logic       last
);
	import ppu_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_mid_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("non-final word while idle");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy)
		else $error("final word while still busy");

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (result_kind == RK_SPAWN || result_kind == RK_EMPTY) |-> last)
		else $error("spawn or empty word not final");

	a_accept_spawn: assert property (@(posedge clk) disable iff (!arst_n)
		valid && accepted |-> result_kind == RK_SPAWN)
		else $error("accepted set on non-spawn word");

endmodule

bind particle_pool_update ppu_chk u_ppu_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.valid       (valid),
	.result_kind (result_kind),
	.accepted    (accepted),
	.last        (last)
);

// File: dv/testbench.sv
// Self-checking testbench for particle_pool_update: spawn/tick words against a local pool model.
module testbench;
	import ppu_pkg::*;

	localparam logic KIND_SPAWN = 1'b0;
	localparam logic KIND_TICK  = 1'b1;
	localparam int   NSLOT      = 32;
	localparam int   WD_LIMIT   = 4000;  // idle cycles with no accept and no result
	localparam int   N_RANDOM   = 260;
	localparam int   N_QUIET    = 40;    // trailing words sent back to back

	typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_HOLD} op_e;

	typedef struct {
		logic               kind;
		logic signed [31:0] px, py, pz, vx, vy, vz, lf;
		logic [15:0]        r, g, b;
		logic [DT_W-1:0]    dt;
	} word_t;

	typedef struct {
		op_e                     op;
		word_t                   w;
		logic signed [GRAV_W-1:0] grav;
		bit                      quiet;
	} job_t;

	typedef struct {
		logic [1:0]         rk;
		logic [SLOT_W-1:0]  slot;
		logic               acc;
		logic signed [31:0] px, py, pz;
		logic [15:0]        r, g, b, a;
		logic               lst;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic [15:0] red = '0, green = '0, blue = '0;
	logic signed [31:0] life = '0;
	logic [DT_W-1:0] delta_time = '0;
	logic cfg_we = 1'b0;
	logic signed [GRAV_W-1:0] cfg_data = '0;
	logic valid;
	logic [1:0] result_kind;
	logic [SLOT_W-1:0] slot;
	logic accepted;
	logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
	logic [15:0] out_red, out_green, out_blue, out_alpha;
	logic last;

	particle_pool_update u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.red(red), .green(green), .blue(blue), .life(life), .delta_time(delta_time),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.valid(valid), .result_kind(result_kind), .slot(slot), .accepted(accepted),
		.out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.out_alpha(out_alpha), .last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// --- pool model: own copy of every slot and of gravity_rate ---
	logic signed [31:0]       m_pos  [NSLOT][3];
	logic signed [31:0]       m_vel  [NSLOT][3];
	logic [15:0]              m_col  [NSLOT][3];
	logic signed [31:0]       m_life [NSLOT];
	int                       m_last_slot;
	logic signed [GRAV_W-1:0] m_grav;

	job_t  job_q[$];     // words and control steps waiting for the driver
	res_t  result_q[$];  // expected output words, oldest first
	word_t cur;
	int    gap;
	int    errors, wd, n_spawn, n_tick, n_surv, n_drop, n_empty, n_cfg;

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			m_life[i] = '0;
			for (int k = 0; k < 3; k++) begin
				m_pos[i][k] = '0;
				m_vel[i][k] = '0;
				m_col[i][k] = '0;
			end
		end
		m_last_slot = 0;
		m_grav = GRAVITY_RESET;
		gap = 0;
		errors = 0;
		wd = 0;
		n_spawn = 0; n_tick = 0; n_surv = 0; n_drop = 0; n_empty = 0; n_cfg = 0;
	end

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Q16.16 product, floor toward minus infinity
	function automatic longint mul_q16(input longint a, input longint b);
		longint p;
		p = a * b;
		return p >>> 16;
	endfunction

	// Advance the model by one accepted word and queue what it must produce.
	task automatic predict_word(input word_t w);
		res_t   r, held;
		bit     have;
		int     found;
		longint dtl, lf;
		r = '{default: '0};
		if (w.kind == KIND_SPAWN) begin
			found = -1;
			for (int i = m_last_slot; i < NSLOT && found < 0; i++)
				if (m_life[i] <= 0) found = i;
			for (int i = 0; i < m_last_slot && found < 0; i++)
				if (m_life[i] <= 0) found = i;
			r.rk = RK_SPAWN;
			r.lst = 1'b1;
			if (found >= 0) begin
				m_last_slot = found;
				m_pos[found][0] = w.px; m_pos[found][1] = w.py; m_pos[found][2] = w.pz;
				m_vel[found][0] = w.vx; m_vel[found][1] = w.vy; m_vel[found][2] = w.vz;
				m_col[found][0] = w.r;  m_col[found][1] = w.g;  m_col[found][2] = w.b;
				m_life[found] = w.lf;
				r.slot = SLOT_W'(found);
				r.acc = 1'b1;
			end
			result_q.insert(result_q.size(), r);
		end else begin
			dtl = w.dt;  // zero-extended
			have = 1'b0;
			held = '{default: '0};
			for (int i = 0; i < NSLOT; i++) begin
				if (m_life[i] <= 0) continue;
				lf = longint'(m_life[i]) - dtl;
				m_life[i] = clamp32(lf);
				if (m_life[i] <= 0) continue;
				// gravity first, then position from the new velocity
				m_vel[i][1] = clamp32(longint'(m_vel[i][1]) + mul_q16(longint'(m_grav), dtl));
				for (int k = 0; k < 3; k++)
					m_pos[i][k] = clamp32(longint'(m_pos[i][k]) +
						mul_q16(longint'(m_vel[i][k]), dtl));
				if (have) result_q.insert(result_q.size(), held);
				held = '{default: '0};
				held.rk = RK_PART;
				held.slot = SLOT_W'(i);
				held.px = m_pos[i][0]; held.py = m_pos[i][1]; held.pz = m_pos[i][2];
				held.r = m_col[i][0];  held.g = m_col[i][1];  held.b = m_col[i][2];
				held.a = (m_life[i] > 65535) ? ALPHA_MAX : m_life[i][15:0];
				have = 1'b1;
			end
			if (have) begin
				held.lst = 1'b1;
				result_q.insert(result_q.size(), held);
			end else begin
				r.rk = RK_EMPTY;
				r.lst = 1'b1;
				result_q.insert(result_q.size(), r);
			end
		end
	endtask

	// --- driver: one start/busy word at a time, random idle bursts between words ---
	always @(posedge clk or negedge arst_n) begin
		logic start_n, we_n;
		job_t j;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			start_n = start;
			we_n = 1'b0;
			if (start && !busy) begin
				predict_word(cur);
				start_n = 1'b0;
			end
			if (!start_n) begin
				if (gap > 0) begin
					gap = gap - 1;
				end else if (job_q.size() > 0) begin
					j = job_q[0];
					if (j.op == OP_WORD) begin
						void'(job_q.pop_front());
						cur = j.w;
						kind <= j.w.kind;
						pos_x <= j.w.px; pos_y <= j.w.py; pos_z <= j.w.pz;
						vel_x <= j.w.vx; vel_y <= j.w.vy; vel_z <= j.w.vz;
						red <= j.w.r; green <= j.w.g; blue <= j.w.b;
						life <= j.w.lf;
						delta_time <= j.w.dt;
						start_n = 1'b1;
						if (!j.quiet && $urandom_range(0, 3) == 0)
							gap = $urandom_range(1, 19);
					end else if (result_q.size() == 0 && !busy && !valid) begin
						// block idle: register write or end of a hold-off
						void'(job_q.pop_front());
						if (j.op == OP_CFG) begin
							we_n = 1'b1;
							cfg_data <= j.grav;
							m_grav = j.grav;
							n_cfg++;
						end
					end
				end
			end
			start <= start_n;
			cfg_we <= we_n;
		end
	end

	task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] g);
		if (e !== g) begin
			errors++;
			$display("%0t mismatch %s: expected %h actual %h", $time, name, e, g);
		end
	endtask

	// --- monitor: every strobed word is compared with the oldest expectation ---
	always @(posedge clk) begin
		res_t e;
		if (arst_n && valid) begin
			if (result_q.size() == 0) begin
				errors++;
				$display("%0t unexpected word: expected none actual kind %0d slot %0d",
					$time, result_kind, slot);
			end else begin
				e = result_q.pop_front();
				check_field("result_kind", e.rk, result_kind);
				check_field("slot", e.slot, slot);
				check_field("accepted", e.acc, accepted);
				check_field("out_pos_x", e.px, out_pos_x);
				check_field("out_pos_y", e.py, out_pos_y);
				check_field("out_pos_z", e.pz, out_pos_z);
				check_field("out_red", e.r, out_red);
				check_field("out_green", e.g, out_green);
				check_field("out_blue", e.b, out_blue);
				check_field("out_alpha", e.a, out_alpha);
				check_field("last", e.lst, last);
				case (e.rk)
					RK_SPAWN: if (e.acc) n_spawn++; else n_drop++;
					RK_PART:  n_surv++;
					default:  n_empty++;
				endcase
				if (e.rk != RK_SPAWN && e.lst) n_tick++;
			end
		end
	end

	// watchdog: cycles with neither an accept nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid)
			wd <= 0;
		else
			wd <= wd + 1;
	end

	// --- stimulus builders ---
	function automatic logic signed [31:0] any32();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h40000) - 32'h20000;
			2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $urandom_range(0, 255) - 128;
		endcase
	endfunction

	function automatic word_t rand_word(input logic k);
		word_t w;
		w.kind = k;
		w.px = any32(); w.py = any32(); w.pz = any32();
		w.vx = any32(); w.vy = any32(); w.vz = any32();
		w.r = 16'($urandom); w.g = 16'($urandom); w.b = 16'($urandom);
		w.lf = any32();
		w.dt = DT_W'($urandom);
		return w;
	endfunction

	task automatic push_word(input word_t w, input bit quiet);
		job_t j;
		j.op = OP_WORD;
		j.w = w;
		j.grav = '0;
		j.quiet = quiet;
		job_q.insert(job_q.size(), j);
	endtask

	task automatic push_ctrl(input op_e op, input int g);
		job_t j;
		j.op = op;
		j.w = rand_word(KIND_TICK);
		j.grav = GRAV_W'(g);
		j.quiet = 1'b0;
		job_q.insert(job_q.size(), j);
	endtask

	task automatic spawn(input int px, py, pz, vx, vy, vz, input int r, g, b, input int lf);
		word_t w;
		w = rand_word(KIND_SPAWN);  // delta_time left random, unused by a spawn
		w.px = px; w.py = py; w.pz = pz;
		w.vx = vx; w.vy = vy; w.vz = vz;
		w.r = 16'(r); w.g = 16'(g); w.b = 16'(b);
		w.lf = lf;
		push_word(w, 1'b0);
	endtask

	task automatic tick(input int dt);
		word_t w;
		w = rand_word(KIND_TICK);
		w.dt = DT_W'(dt);
		push_word(w, 1'b0);
	endtask

	initial begin
		int n;
		bit q;
		word_t w;
		bit timed_out;

		// directed: extremes, dead spawns, saturation, alpha clip, empty tick
		tick(0);                                        // nothing alive
		spawn(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, -1,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF);
		spawn(32'h80000000, 32'h7FFFFFFF, -1, 32'h80000000, 32'h7FFFFFFF, 1,
			0, 0, 0, 1);
		spawn(5, 6, 7, 8, 9, 10, 16'h1234, 16'h5678, 16'h9ABC, 0);          // stored dead
		spawn(1, 2, 3, 4, 5, 6, 16'hAAAA, 16'h5555, 16'h0F0F, 32'h80000000);
		spawn(32'h10000, 32'h20000, 32'h30000, 32'h8000, 32'h10000, 32'hFFFF8000,
			16'h8000, 16'h0001, 16'hFFFE, 40000);                          // alpha below one
		tick(1);
		tick(32'h1FFFFF);                               // every delta_time bit set
		tick(0);
		spawn(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			16'h00FF, 16'hFF00, 16'h0FF0, 32'h7FFFFFFF);
		tick(32'h100000);                               // 16.0 s, saturating sums
		tick(32'h0AAAAA);
		tick(32'h155555);
		push_ctrl(OP_HOLD, 0);
		push_ctrl(OP_CFG, 8388608);                     // gravity_rate of 2^23
		spawn(0, 0, 0, 0, 32'h7FFF0000, 0, 1, 2, 3, 32'h300000);
		tick(32'h1FFFFF);
		push_ctrl(OP_CFG, -8388608);                    // gravity_rate of -2^23
		spawn(0, 0, 0, 0, 32'h80010000, 0, 4, 5, 6, 32'h300000);
		tick(32'h1FFFFF);
		tick(32'h10000);
		tick(32'h1FFFFF);

		// random: mostly spawn runs closed by a tick, with pool fills and noise
		n = 0;
		while (n < N_RANDOM) begin
			q = (n >= N_RANDOM - N_QUIET);
			if (n > 0 && n % 70 < 3 && !q) begin
				push_ctrl(OP_HOLD, 0);
				push_ctrl(OP_CFG, $urandom_range(0, 3) == 0 ?
					($urandom_range(0, 1) ? 8388608 : -8388608) :
					int'($urandom_range(0, 16777216)) - 8388608);
			end
			case ($urandom_range(0, 9))
				0: begin
					push_word(rand_word(1'($urandom_range(0, 1))), q);
					n++;
				end
				1: begin
					// fill the pool past full, age it, then wipe it out
					for (int i = 0; i < 34 + $urandom_range(0, 3); i++) begin
						w = rand_word(KIND_SPAWN);
						w.lf = $urandom_range(32'h10000, 32'h1F0000);
						push_word(w, q);
						n++;
					end
					w = rand_word(KIND_TICK);
					w.dt = DT_W'($urandom_range(0, 32'h8000));
					push_word(w, q);
					w.dt = 21'h1FFFFF;
					push_word(w, q);
					n += 2;
				end
				default: begin
					for (int i = 0; i < $urandom_range(1, 6); i++) begin
						w = rand_word(KIND_SPAWN);
						w.lf = $urandom_range(0, 9) == 0 ? any32() : $urandom_range(1, 32'h80000);
						push_word(w, q);
						n++;
					end
					w = rand_word(KIND_TICK);
					if ($urandom_range(0, 4) != 0)
						w.dt = DT_W'($urandom_range(0, 32'h20000));
					push_word(w, q);
					n++;
				end
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// run until all words are in and every expected word has come out
		timed_out = 1'b0;
		while (job_q.size() > 0 || start || result_q.size() > 0 || busy) begin
			@(posedge clk);
			if (wd >= WD_LIMIT) begin
				timed_out = 1'b1;
				break;
			end
		end
		if (!timed_out) begin
			repeat (60) @(posedge clk);  // room for a last tick to drain
			if (result_q.size() > 0) begin
				errors++;
				$display("%0t %0d expected words never arrived", $time, result_q.size());
			end
		end

		$display("covered: %0d spawns stored, %0d dropped on a full pool, %0d ticks",
			n_spawn, n_drop, n_tick);
		$display("covered: %0d survivor words, %0d empty ticks, %0d gravity writes",
			n_surv, n_empty, n_cfg);
		if (timed_out) begin
			$display("%0t watchdog expired", $time);
			$display("testbench: FAIL");
		end else if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
